[sv/sha512_pkg.sv]
// ----------------------------------------------------------------------------
// sha512_pkg
// shared constants, round constant table and command/status types
// ----------------------------------------------------------------------------
package sha512_pkg;

    localparam int Rounds     = 80;
    localparam int BlockWords = 16;
    localparam int LenPos     = 14;

    localparam logic [63:0] PAD_MARK = 64'h8000000000000000;

    // controller to datapath commands
    typedef enum logic [2:0] {
        WCMD_NONE  = 3'd0,
        WCMD_DATA  = 3'd1,   // store the word as taken
        WCMD_LAST  = 3'd2,   // store masked word with pad mark
        WCMD_MARK  = 3'd3,   // store lone pad mark word
        WCMD_ZERO  = 3'd4,   // store zero fill
        WCMD_LENHI = 3'd5,
        WCMD_LENLO = 3'd6
    } wcmd_t;

    typedef struct packed {
        wcmd_t      wcmd;
        logic       round_start;  // load working regs from chain value
        logic       round_en;     // run one round
        logic       fold;         // add working regs into chain value
        logic       len_add;      // add bit count of the accepted word
        logic       restart;      // back to initial hash and zero length
    } dp_cmd_t;

    typedef struct packed {
        logic [4:0] words;        // words gathered in the current block
        logic [6:0] round;        // current round
    } dp_status_t;

    function automatic logic [63:0] init_hash(input logic [2:0] i);
        logic [63:0] v;
        case (i)
            3'd0: v = 64'h6a09e667f3bcc908;
            3'd1: v = 64'hbb67ae8584caa73b;
            3'd2: v = 64'h3c6ef372fe94f82b;
            3'd3: v = 64'ha54ff53a5f1d36f1;
            3'd4: v = 64'h510e527fade682d1;
            3'd5: v = 64'h9b05688c2b3e6c1f;
            3'd6: v = 64'h1f83d9abfb41bd6b;
            default: v = 64'h5be0cd19137e2179;
        endcase
        return v;
    endfunction

    localparam logic [63:0] K_TABLE [0:79] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

endpackage

[sv/sha512_dp.sv]
// ----------------------------------------------------------------------------
// sha512_dp
// block buffer, message schedule, round logic, chain value and bit length
// ----------------------------------------------------------------------------
module sha512_dp
    import sha512_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [63:0] in_word,
    input  logic [3:0]  in_bytes,
    input  logic        in_last,
    input  logic [2:0]  rd_index,
    output logic [63:0] rd_word,
    output dp_status_t  status
);

    logic [63:0] w_reg [0:15];
    logic [63:0] h_reg [0:7];
    logic [63:0] v_reg [0:7];
    logic [4:0]  words_reg;
    logic [6:0]  round_reg;
    logic [127:0] bits_reg;

    logic [3:0]  nbytes;
    logic [63:0] keep;
    logic [63:0] mark;
    logic [63:0] wr_data;
    logic [3:0]  t;
    logic [63:0] wa, wb, s0, s1, wt;
    logic [63:0] t1, t2;
    logic [127:0] add_amt;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // padding of the final word, buffer write data and length increment
    always_comb
    begin
        nbytes = (in_bytes > 4'd8) ? 4'd8 : in_bytes;
        keep = (nbytes == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {nbytes[2:0], 3'b000});
        mark = 64'h80 << (7'd56 - {nbytes[2:0], 3'b000});
        if (in_last)
            add_amt = {121'd0, nbytes, 3'b000};
        else
            add_amt = 128'd64;
        case (cmd.wcmd)
            WCMD_DATA:  wr_data = in_word;
            WCMD_LAST:  wr_data = (in_word & keep) | mark;
            WCMD_MARK:  wr_data = PAD_MARK;
            WCMD_LENHI: wr_data = bits_reg[127:64];
            WCMD_LENLO: wr_data = bits_reg[63:0];
            default:    wr_data = 64'd0;
        endcase
    end

    // schedule and round functions: rounds 16 and up rewrite their slot of the window
    always_comb
    begin
        t  = round_reg[3:0];
        wa = w_reg[t - 4'd2];
        wb = w_reg[t - 4'd15];
        s1 = rotr(wa, 19) ^ rotr(wa, 61) ^ (wa >> 6);
        s0 = rotr(wb, 1) ^ rotr(wb, 8) ^ (wb >> 7);
        if (round_reg >= 7'(BlockWords))
            wt = w_reg[t] + s1 + w_reg[t - 4'd7] + s0;
        else
            wt = w_reg[t];
        t1 = v_reg[7] + (rotr(v_reg[4], 14) ^ rotr(v_reg[4], 18) ^ rotr(v_reg[4], 41))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + K_TABLE[round_reg] + wt;
        t2 = (rotr(v_reg[0], 28) ^ rotr(v_reg[0], 34) ^ rotr(v_reg[0], 39))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wcmd != WCMD_NONE)
            w_reg[words_reg[3:0]] <= wr_data;
        else if (cmd.round_en)
            w_reg[t] <= wt;
        if (cmd.round_start)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        else if (cmd.round_en)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_hash(3'(i));
            words_reg <= '0;
            round_reg <= '0;
            bits_reg  <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= init_hash(3'(i));
                bits_reg <= '0;
            end
            else
            begin
                if (cmd.fold)
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                if (cmd.len_add)
                    bits_reg <= bits_reg + add_amt;
            end
            if (cmd.wcmd != WCMD_NONE)
                words_reg <= words_reg + 5'd1;
            else if (cmd.fold)
                words_reg <= '0;
            if (cmd.round_start)
                round_reg <= '0;
            else if (cmd.round_en)
                round_reg <= round_reg + 7'd1;
        end
    end

    assign rd_word       = h_reg[rd_index];
    assign status.words  = words_reg;
    assign status.round  = round_reg;

    property p_words_bound;
        @(posedge clk) disable iff (!rst_n) words_reg <= 5'(BlockWords);
    endproperty
    assert property (p_words_bound) else $error("block word count overflow");

    property p_round_bound;
        @(posedge clk) disable iff (!rst_n) round_reg <= 7'(Rounds);
    endproperty
    assert property (p_round_bound) else $error("round count overflow");

    property p_no_write_in_rounds;
        @(posedge clk) disable iff (!rst_n) cmd.round_en |-> cmd.wcmd == WCMD_NONE;
    endproperty
    assert property (p_no_write_in_rounds) else $error("buffer write during rounds");

endmodule

[sv/sha512_ctrl.sv]
// ----------------------------------------------------------------------------
// sha512_ctrl
// sequencer for word intake, padding, compression and digest output
// ----------------------------------------------------------------------------
module sha512_ctrl
    import sha512_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_last,
    input  logic [3:0]  in_bytes,
    output logic        in_stall,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [2:0]  out_index,
    input  dp_status_t  status,
    output dp_cmd_t     cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MARK  = 3'd1;   // lone pad mark word
    localparam logic [2:0] S_FILL  = 3'd2;   // zero fill and length words
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_ROUND = 3'd4;
    localparam logic [2:0] S_FOLD  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       pad_reg, pad_next;     // padding in progress
    logic       mark_reg, mark_next;   // pad mark owed after a full final word
    logic       fit_reg, fit_next;     // length words go in the current block
    logic       done_reg, done_next;   // length words written
    logic [2:0] idx_reg, idx_next;
    logic       accept;
    logic       full;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = (state_reg == S_OUT);
    assign out_index = idx_reg;

    always_comb
    begin
        state_next = state_reg;
        pad_next   = pad_reg;
        mark_next  = mark_reg;
        fit_next   = fit_reg;
        done_next  = done_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.wcmd   = WCMD_NONE;
        full       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.len_add = 1'b1;
                    full = (status.words == 5'(BlockWords - 1));
                    if (!in_last)
                    begin
                        cmd.wcmd = WCMD_DATA;
                        if (full)
                            state_next = S_START;
                    end
                    else
                    begin
                        pad_next = 1'b1;
                        if (in_bytes >= 4'd8)
                        begin
                            cmd.wcmd = WCMD_DATA;
                            mark_next = full;
                            state_next = full ? S_START : S_MARK;
                        end
                        else
                        begin
                            // mark shares the word; length fits if it lands before slot 14
                            cmd.wcmd = WCMD_LAST;
                            fit_next = (status.words < 5'(LenPos));
                            state_next = full ? S_START : S_FILL;
                        end
                    end
                end
            end
            S_MARK:
            begin
                cmd.wcmd = WCMD_MARK;
                mark_next = 1'b0;
                fit_next = (status.words < 5'(LenPos));
                state_next = (status.words == 5'(BlockWords - 1)) ? S_START : S_FILL;
            end
            S_FILL:
            begin
                if (fit_reg && status.words == 5'(LenPos))
                    cmd.wcmd = WCMD_LENHI;
                else if (fit_reg && status.words == 5'(LenPos + 1))
                begin
                    cmd.wcmd = WCMD_LENLO;
                    done_next = 1'b1;
                end
                else
                    cmd.wcmd = WCMD_ZERO;
                if (status.words == 5'(BlockWords - 1))
                    state_next = S_START;
            end
            S_START:
            begin
                cmd.round_start = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (status.round == 7'(Rounds - 1))
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.fold = 1'b1;
                if (!pad_reg)
                    state_next = S_IDLE;
                else if (mark_reg)
                    state_next = S_MARK;
                else if (done_reg)
                    state_next = S_OUT;
                else
                begin
                    // extra block of zero fill ending in the length
                    fit_next = 1'b1;
                    state_next = S_FILL;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.restart = 1'b1;
                        pad_next = 1'b0;
                        fit_next = 1'b0;
                        done_next = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pad_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            fit_reg   <= 1'b0;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pad_reg   <= pad_next;
            mark_reg  <= mark_next;
            fit_reg   <= fit_next;
            done_reg  <= done_next;
            idx_reg   <= idx_next;
        end
    end

    property p_out_only_padded;
        @(posedge clk) disable iff (!rst_n) out_valid |-> pad_reg;
    endproperty
    assert property (p_out_only_padded) else $error("digest without padding");

    property p_stall_busy;
        @(posedge clk) disable iff (!rst_n) (state_reg == S_ROUND) |-> in_stall;
    endproperty
    assert property (p_stall_busy) else $error("intake open during rounds");

    property p_restart_end;
        @(posedge clk) disable iff (!rst_n) cmd.restart |-> idx_reg == 3'd7;
    endproperty
    assert property (p_restart_end) else $error("restart before last digest word");

endmodule

[sv/sha512_hash_core.sv]
// ----------------------------------------------------------------------------
// sha512_hash_core
// SHA-512 engine: gathers 64-bit message words, pads, compresses, and
// returns the eight digest words per message
// ----------------------------------------------------------------------------
//  channel  | signals                                        | direction
//  ---------+------------------------------------------------+----------
//  message  | valid, stall, data_word, valid_bytes, last_word | in
//  digest   | digest_valid, digest_stall, digest_word/index/end | out
//
//  non-last words are accepted while the core is idle; a word that completes a
//  16-word block is followed by start, 80 rounds and fold, with intake stalled
//  the last word adds padding words (one per cycle), one or two block
//  compressions, then eight digest words, one per cycle while not stalled
//  round rate is set by the single round unit, one round per cycle
//  rst_n clears the controller and restores the initial hash value
//  a stalled digest word holds; intake stays stalled until delivery ends
// ----------------------------------------------------------------------------
module sha512_hash_core
    import sha512_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        stall,
    input  logic [63:0] data_word,
    input  logic [3:0]  valid_bytes,
    input  logic        last_word,
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [63:0] digest_word,
    output logic [2:0]  digest_index,
    output logic        digest_end
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [2:0] idx;

    // sequencer
    sha512_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid),
        .in_last   (last_word),
        .in_bytes  (valid_bytes),
        .in_stall  (stall),
        .out_stall (digest_stall),
        .out_valid (digest_valid),
        .out_index (idx),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    sha512_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_word  (data_word),
        .in_bytes (valid_bytes),
        .in_last  (last_word),
        .rd_index (idx),
        .rd_word  (digest_word),
        .status   (status)
    );

    assign digest_index = idx;
    assign digest_end   = (idx == 3'd7);

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// SHA-512 core testbench: directed and random messages against a local
// digest predictor, random idling on both channels, one long digest hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb
    import sha512_pkg::*;
();

    localparam int WatchdogLimit = 20000;

    logic        clk;
    logic        rst_n;
    logic        valid;
    logic        stall;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
    logic        digest_valid;
    logic        digest_stall;
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_end;

    sha512_hash_core dut (
        .clk(clk), .rst_n(rst_n), .valid(valid), .stall(stall),
        .data_word(data_word), .valid_bytes(valid_bytes), .last_word(last_word),
        .digest_valid(digest_valid), .digest_stall(digest_stall),
        .digest_word(digest_word), .digest_index(digest_index), .digest_end(digest_end)
    );

    typedef struct packed {
        logic [63:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_t;

    // predictor state
    logic [63:0] hash_state [8];
    logic [63:0] block_buf [16];
    int          block_fill;
    logic [127:0] bit_count;

    digest_t     digest_queue [$];
    int          error_count;
    int          request_count;
    int          digest_count;
    int          message_count;
    int          idle_cycles;
    bit          send_idle_en;
    bit          recv_idle_en;
    bit          hold_off;

    always
    begin
        clk = 1'b0; #4;
        clk = 1'b1; #4;
    end

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic compress_block();
        logic [63:0] r [8];
        logic [63:0] w [16];
        logic [63:0] a, b, t1, t2;
        for (int i = 0; i < 8; i++) r[i] = hash_state[i];
        for (int i = 0; i < 16; i++) w[i] = block_buf[i];
        for (int t = 0; t < Rounds; t++)
        begin
            if (t >= 16)
            begin
                a = w[(t - 2) & 15];
                b = w[(t - 15) & 15];
                w[t & 15] = w[t & 15] + (rotr(a, 19) ^ rotr(a, 61) ^ (a >> 6))
                          + w[(t - 7) & 15] + (rotr(b, 1) ^ rotr(b, 8) ^ (b >> 7));
            end
            t1 = r[7] + (rotr(r[4], 14) ^ rotr(r[4], 18) ^ rotr(r[4], 41))
               + ((r[4] & r[5]) ^ (~r[4] & r[6])) + K_TABLE[t] + w[t & 15];
            t2 = (rotr(r[0], 28) ^ rotr(r[0], 34) ^ rotr(r[0], 39))
               + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
            r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
            r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + r[i];
    endtask

    task automatic load_word(input logic [63:0] w);
        block_buf[block_fill] = w;
        block_fill++;
        if (block_fill == 16)
        begin
            compress_block();
            block_fill = 0;
        end
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) hash_state[i] = init_hash(i[2:0]);
        block_fill = 0;
        bit_count = '0;
    endtask

    // next expected state for one accepted request
    task automatic predict_digest(input logic [63:0] d, input logic [3:0] nb_in,
                                  input logic lw);
        int nb;
        logic [63:0] keep;
        if (!lw)
        begin
            load_word(d);
            bit_count = bit_count + 128'd64;
            return;
        end
        nb = (nb_in > 8) ? 8 : nb_in;
        bit_count = bit_count + 128'(nb * 8);
        if (nb == 8)
        begin
            load_word(d);
            load_word(PAD_MARK);
        end
        else
        begin
            keep = (nb == 0) ? 64'd0 : ~64'd0 << (64 - 8 * nb);
            load_word((d & keep) | (64'h80 << (56 - 8 * nb)));
        end
        while (block_fill != LenPos) load_word(64'd0);
        load_word(bit_count[127:64]);
        load_word(bit_count[63:0]);
        for (int i = 0; i < 8; i++)
            digest_queue.push_back('{hash_state[i], 3'(i), i == 7});
        restart_hash();
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    // send one request, predicted on acceptance; valid is left high on return
    task automatic send_request(input logic [63:0] d, input logic [3:0] nb,
                                input logic lw);
        while (send_idle_en && $urandom_range(99) < 25)
        begin
            valid <= 1'b0;
            @(negedge clk);
        end
        valid       <= 1'b1;
        data_word   <= d;
        valid_bytes <= nb;
        last_word   <= lw;
        @(posedge clk);
        while (stall) @(posedge clk);
        predict_digest(d, nb, lw);
        request_count++;
        if (lw) message_count++;
        @(negedge clk);
    endtask

    // message of n full words then a last word with nb valid bytes
    task automatic send_message(input int n, input logic [3:0] nb);
        for (int i = 0; i < n; i++)
            send_request({$urandom, $urandom}, 4'd8, 1'b0);
        send_request({$urandom, $urandom}, nb, 1'b1);
    endtask

    task automatic wait_drained();
        valid <= 1'b0;
        while (digest_queue.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // digest checker
    always @(posedge clk)
    begin
        digest_t want;
        if (rst_n && digest_valid && !digest_stall)
        begin
            digest_count++;
            if (digest_queue.size() == 0)
                report_mismatch("unexpected digest", digest_word, 64'd0);
            else
            begin
                want = digest_queue.pop_front();
                if (digest_word !== want.word)
                    report_mismatch("digest_word", digest_word, want.word);
                if (digest_index !== want.index)
                    report_mismatch("digest_index", 64'(digest_index), 64'(want.index));
                if (digest_end !== want.last)
                    report_mismatch("digest_end", 64'(digest_end), 64'(want.last));
            end
        end
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (hold_off)
            digest_stall <= 1'b1;
        else
            digest_stall <= recv_idle_en && ($urandom_range(99) < 25);
    end

    // watchdog on cycles with no accepted transfer
    always @(posedge clk)
    begin
        if ((valid && !stall) || (digest_valid && !digest_stall) || !rst_n)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("watchdog expired");
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // edges of the length field: empty, all byte counts, counts above eight, block ends
    task automatic test_directed();
        send_request(64'd0, 4'd0, 1'b1);
        send_request(~64'd0, 4'd8, 1'b1);
        for (int nb = 1; nb <= 7; nb++)
            send_request({$urandom, $urandom}, 4'(nb), 1'b1);
        send_request(~64'd0, 4'd15, 1'b1);
        send_request(64'h0123456789abcdef, 4'd9, 1'b1);
        // partial word not last is taken whole
        send_request(~64'd0, 4'd3, 1'b0);
        send_request(64'd0, 4'd0, 1'b1);
        // last full word just before block end, and last word at block end; both force a second pad block
        send_message(14, 4'd8);
        send_message(15, 4'd4);
        wait_drained();
    endtask

    // digest channel held while the sender fills the core
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                send_message(3, 4'd5);
                send_message(2, 4'd8);
                valid <= 1'b0;
            end
            begin
                repeat (600) @(negedge clk);
                hold_off = 1'b0;
            end
        join
        wait_drained();
    endtask

    // random messages, mostly short, some spanning several blocks
    task automatic test_random();
        int n;
        while (request_count < 420)
        begin
            if ($urandom_range(9) == 0) n = $urandom_range(40);
            else n = $urandom_range(6);
            send_message(n, 4'($urandom_range(15)));
            if ($urandom_range(19) == 0)
            begin
                send_idle_en = ~send_idle_en;
                recv_idle_en = ~recv_idle_en;
            end
        end
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        valid = 1'b0;
        data_word = '0;
        valid_bytes = 4'd8;
        last_word = 1'b0;
        error_count = 0;
        request_count = 0;
        digest_count = 0;
        message_count = 0;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        hold_off = 1'b0;
        restart_hash();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_backpressure();
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        test_random();

        $display("covered %0d requests in %0d messages, %0d digest words checked",
                 request_count, message_count, digest_count);
        if (error_count == 0 && digest_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
